@@ sv/fcpc_pkg.sv @@
`timescale 1ns / 1ps

package fcpc_pkg;

	// Framing
	localparam logic [7:0] START_BYTE = 8'hFF;
	localparam logic [7:0] FORCE_BYTE = 8'hFF;
	localparam int PKT_DATA_BYTES = 3;
	localparam int IDX_W = 3;
	localparam int SLOT_W = 2;

	// Command codes
	localparam logic [7:0] CMD_LAMP_DARK = 8'h00;
	localparam logic [7:0] CMD_LAMP_LIT = 8'h01;
	localparam logic [7:0] CMD_PERIOD = 8'h02;
	localparam logic [7:0] CMD_DUTY = 8'h03;
	localparam logic [7:0] CMD_SHUTDOWN = 8'h04;

	// Status codes
	typedef enum logic [2:0] {
		ST_LED_OFF = 3'd0,
		ST_LED_ON = 3'd1,
		ST_PERIOD = 3'd2,
		ST_DUTY = 3'd3,
		ST_ALL_OFF = 3'd4,
		ST_UNKNOWN = 3'd5
	} status_t;

	// PWM reset values and minimum period
	localparam logic [15:0] PERIOD_RESET = 16'd1999;
	localparam logic [15:0] DUTY_RESET = 16'd1000;
	localparam logic [15:0] PERIOD_MIN = 16'd1;

endpackage

@@ sv/framed_command_pwm_controller_unit.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  rx_byte[7:0]
// out       output     out_valid/out_stall  command, value, status, led_on,
//                                           pwm_running, pwm_period, pwm_duty
//
// One byte per cycle while no escape byte waits; each byte passes through the input
// register, and a packet result is loaded into the output register at the edge its
// escape byte leaves the input register.
// Bytes that produce no result drain even while the output register is full;
// only an escape byte waits for the output register to free up.
// arst_n clears framing, LED, run flag and loads period 1999 / duty 1000.
module framed_command_pwm_controller_unit
	import fcpc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  command,
	output logic [15:0] value,
	output logic [2:0]  status,
	output logic        led_on,
	output logic        pwm_running,
	output logic [15:0] pwm_period,
	output logic [15:0] pwm_duty
);

	// Input register
	logic             valid_s1;
	logic [7:0]       byte_s1;

	// Framing and PWM state
	logic             collecting_q;
	logic [IDX_W-1:0] byte_index_q;
	logic [7:0]       pkt_store_q [PKT_DATA_BYTES];
	logic             led_q;
	logic [15:0]      period_q;
	logic [15:0]      duty_q;
	logic             running_q;

	// Result register
	logic             out_valid_q;
	logic [7:0]       command_q;
	logic [15:0]      value_q;
	status_t          status_q;

	// Combinational decode
	logic             in_data_pos;
	logic             is_escape;
	logic             out_free;
	logic             advance;
	logic             take_in;
	logic [SLOT_W-1:0] slot;
	logic [7:0]       hi_byte;
	logic [7:0]       lo_byte;
	logic [15:0]      pkt_value;
	logic [15:0]      new_period;
	logic [15:0]      new_duty;
	logic             new_led;
	logic             new_running;
	status_t          new_status;

	// Byte position within a packet
	assign in_data_pos = (byte_index_q >= IDX_W'(1)) &&
		(byte_index_q <= IDX_W'(PKT_DATA_BYTES));
	assign is_escape = collecting_q && !in_data_pos;
	assign slot = byte_index_q[SLOT_W-1:0] - SLOT_W'(1);

	// Flow control
	assign out_free = !out_valid_q || !out_stall;
	assign advance = valid_s1 && (!is_escape || out_free);
	assign in_stall = valid_s1 && !advance;
	assign take_in = in_valid && !in_stall;

	// Escape correction
	assign hi_byte = byte_s1[0] ? FORCE_BYTE : pkt_store_q[1];
	assign lo_byte = byte_s1[1] ? FORCE_BYTE : pkt_store_q[2];
	assign pkt_value = {hi_byte, lo_byte};

	// Command decode
	always_comb begin
		new_period = period_q;
		new_duty = duty_q;
		new_led = led_q;
		new_running = running_q;
		new_status = ST_UNKNOWN;
		unique case (pkt_store_q[0])
			CMD_LAMP_DARK: begin
				new_led = 1'b0;
				new_status = ST_LED_OFF;
			end
			CMD_LAMP_LIT: begin
				new_led = 1'b1;
				new_status = ST_LED_ON;
			end
			CMD_PERIOD: begin
				new_period = (pkt_value == 16'd0) ? PERIOD_MIN : pkt_value;
				new_duty = (duty_q > new_period) ? new_period : duty_q;
				new_running = 1'b1;
				new_status = ST_PERIOD;
			end
			CMD_DUTY: begin
				new_duty = (pkt_value > period_q) ? period_q : pkt_value;
				new_running = 1'b1;
				new_status = ST_DUTY;
			end
			CMD_SHUTDOWN: begin
				new_running = 1'b0;
				new_led = 1'b0;
				new_status = ST_ALL_OFF;
			end
			default: begin
				new_status = ST_UNKNOWN;
			end
		endcase
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in || advance) begin
			valid_s1 <= take_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= rx_byte;
		end
	end

	// Framing and PWM state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			byte_index_q <= '0;
			led_q <= 1'b0;
			period_q <= PERIOD_RESET;
			duty_q <= DUTY_RESET;
			running_q <= 1'b0;
		end else if (advance) begin
			if (!collecting_q) begin
				if (byte_s1 == START_BYTE) begin
					collecting_q <= 1'b1;
					byte_index_q <= IDX_W'(1);
				end
			end else if (in_data_pos) begin
				byte_index_q <= byte_index_q + IDX_W'(1);
			end else begin
				collecting_q <= 1'b0;
				byte_index_q <= '0;
				led_q <= new_led;
				period_q <= new_period;
				duty_q <= new_duty;
				running_q <= new_running;
			end
		end
	end

	// Packet byte store
	always_ff @(posedge clk) begin
		if (advance && collecting_q && in_data_pos) begin
			pkt_store_q[slot] <= byte_s1;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_escape) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_escape) begin
			command_q <= pkt_store_q[0];
			value_q <= pkt_value;
			status_q <= new_status;
		end
	end

	// LED and PWM outputs follow the state, which only changes on a result
	assign out_valid = out_valid_q;
	assign command = command_q;
	assign value = value_q;
	assign status = status_q;
	assign led_on = led_q;
	assign pwm_running = running_q;
	assign pwm_period = period_q;
	assign pwm_duty = duty_q;

endmodule
